>>> src/affine_transform_accumulator_macros.svh
// assertion macros for the affine transform accumulator checker
`ifndef AFFINE_TRANSFORM_ACCUMULATOR_MACROS_SVH
`define AFFINE_TRANSFORM_ACCUMULATOR_MACROS_SVH
// implication checked every clock, masked during reset
`define ATA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication, masked during reset
`define ATA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> src/ata_pkg.sv
// ----------------------------------------------------------------------------
// ata_pkg
// shared types and constants of the transform block, fixed point defaults included
// ----------------------------------------------------------------------------
package ata_pkg;

  localparam int WORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int IO_WIDTH       = 32;
  localparam int LANES          = 4;

  localparam logic [2:0] MODE_TRANSLATE = 3'd0;
  localparam logic [2:0] MODE_SET_POS   = 3'd1;
  localparam logic [2:0] MODE_CLEAR_ROT = 3'd2;
  localparam logic [2:0] MODE_OPERAND   = 3'd3;
  localparam logic [2:0] MODE_POINT     = 3'd4;
  localparam logic [2:0] MODE_READ_POS  = 3'd5;
  localparam logic [2:0] MODE_INVERSE   = 3'd6;

  // what a lane is asked to do in one pass
  typedef struct packed {
    logic       vld;
    logic       emit;
    logic       wr_row;
    logic       negate;
    logic       use_bias;
    logic       last;
    logic [1:0] row;
  } lane_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_COMPOSE = 4'b0010,
    ST_INVERSE = 4'b0100,
    ST_SPARE   = 4'b1000
  } seq_state_t;

endpackage

>>> src/ata_lane.sv
// ----------------------------------------------------------------------------
// ata_lane
// one dot product lane: four truncated products, a bias term, optional negation, saturation
// ----------------------------------------------------------------------------
module ata_lane #(
  parameter int WORD_WIDTH = ata_pkg::WORD_WIDTH_DEF,
  parameter int FRAC_BITS  = ata_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [WORD_WIDTH-1:0] a [4],
  input  logic signed [WORD_WIDTH-1:0] b [4],
  input  logic signed [WORD_WIDTH-1:0] bias,
  input  logic                         negate,
  output logic signed [WORD_WIDTH-1:0] res
);
  localparam int PW = 2 * WORD_WIDTH;
  localparam int SW = PW + 3;

  logic signed [PW-1:0] prod [4];
  logic signed [WORD_WIDTH-1:0] bias_q;
  logic negate_q;
  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] wmax;
  logic signed [SW-1:0] wmin;

  // products registered before the adder tree
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        prod[i] <= (PW'(a[i]) * PW'(b[i])) >>> FRAC_BITS;
      end
      bias_q   <= bias;
      negate_q <= negate;
    end
  end

  always_comb begin
    sum = SW'(prod[0]) + SW'(prod[1]) + SW'(prod[2]) + SW'(prod[3]) + SW'(bias_q);
    if (negate_q) begin
      sum = -sum;
    end
    wmax = SW'({1'b0, {(WORD_WIDTH-1){1'b1}}});
    wmin = -wmax - SW'(1);
    if (sum > wmax) begin
      res = wmax[WORD_WIDTH-1:0];
    end else if (sum < wmin) begin
      res = wmin[WORD_WIDTH-1:0];
    end else begin
      res = sum[WORD_WIDTH-1:0];
    end
  end
endmodule

>>> src/affine_transform_accumulator.sv
// ----------------------------------------------------------------------------
// affine_transform_accumulator
// 4x4 row-vector affine transform in signed fixed point, updated and used
// ----------------------------------------------------------------------------
// usage: one input channel (valid/ready, mode, frame, row_index, val0..val3)
// and one result channel (valid/ready, out_row, res0..res3, last).
// set position, clear rotation and row stores (mode 3 rows 0..2) are taken
// one per cycle while ready is high, and give no result.
// translate and operand row 3 compose the operand with the held transform:
// four lanes of four multipliers form one result row per pass, four passes
// then a write-back; the next input is taken after the write-back.
// point transform and position read are taken one per cycle while results are
// not stalled; each passes the product stage, then the output register.
// read inverse gives four transactions, one row per cycle unless the
// receiver stalls; the next input is taken once the last row pass is issued.
// reset loads the identity and empties the output register; the operand
// rows are undefined until written. when the receiver stalls, the result
// held in the output register waits and the lanes stall behind it; ready is
// low in compose and inverse passes, in write-back and while a stalled result blocks.
// ----------------------------------------------------------------------------
module affine_transform_accumulator #(
  parameter int WORD_WIDTH = ata_pkg::WORD_WIDTH_DEF,
  parameter int FRAC_BITS  = ata_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  mode,
  input  logic        frame,
  input  logic [1:0]  row_index,
  input  logic signed [31:0] val0,
  input  logic signed [31:0] val1,
  input  logic signed [31:0] val2,
  input  logic signed [31:0] val3,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_row,
  output logic signed [31:0] res0,
  output logic signed [31:0] res1,
  output logic signed [31:0] res2,
  output logic signed [31:0] res3,
  output logic        last
);
  localparam int W  = WORD_WIDTH;
  localparam int IW = ata_pkg::IO_WIDTH;
  localparam logic signed [W:0] ONE_WIDE = (W+1)'(1) <<< FRAC_BITS;
  localparam logic signed [W:0] MAXW = (W+1)'({1'b0, {(W-1){1'b1}}});
  localparam logic signed [W-1:0] ONE =
    (ONE_WIDE > MAXW) ? MAXW[W-1:0] : ONE_WIDE[W-1:0];

  logic signed [W-1:0] m      [16];
  logic signed [W-1:0] op     [16];
  logic signed [W-1:0] opx    [16];
  logic signed [W-1:0] vin    [4];
  logic signed [W-1:0] newrow [4];

  ata_pkg::seq_state_t state, state_next;
  logic       world;
  logic       is_trn;
  logic [1:0] pass;

  ata_pkg::lane_ctl_t ctl_s, ctl_q;   // issue and pipeline stage
  logic signed [W-1:0] la [ata_pkg::LANES][4];
  logic signed [W-1:0] lb [ata_pkg::LANES][4];
  logic signed [W-1:0] lbias [ata_pkg::LANES];
  logic signed [W-1:0] lres [ata_pkg::LANES];

  logic signed [W-1:0] cmp_buf [16];
  logic adv;
  logic accept;

  // input saturation to word width
  function automatic logic signed [W-1:0] load_f(input logic signed [IW-1:0] x);
    logic signed [IW+W-1:0] xe;
    logic signed [IW+W-1:0] hi;
    logic signed [IW+W-1:0] lo;
    xe = (IW+W)'(x);
    hi = (IW+W)'({1'b0, {(W-1){1'b1}}});
    lo = -hi - (IW+W)'(1);
    if (xe > hi) return hi[W-1:0];
    if (xe < lo) return lo[W-1:0];
    return xe[W-1:0];
  endfunction

  function automatic logic signed [IW-1:0] emit_f(input logic signed [W-1:0] x);
    logic signed [IW+W-1:0] xe;
    logic signed [IW+W-1:0] hi;
    logic signed [IW+W-1:0] lo;
    xe = (IW+W)'(x);
    hi = (IW+W)'({1'b0, {(IW-1){1'b1}}});
    lo = -hi - (IW+W)'(1);
    if (xe > hi) return hi[IW-1:0];
    if (xe < lo) return lo[IW-1:0];
    return xe[IW-1:0];
  endfunction

  assign vin[0] = load_f(val0);
  assign vin[1] = load_f(val1);
  assign vin[2] = load_f(val2);
  assign vin[3] = load_f(val3);

  // translate uses identity rows 0..2, so the staged operand rows survive
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      opx[i] = (is_trn && i < 12) ? ((i % 5 == 0) ? ONE : '0) : op[i];
    end
  end

  // pipeline advances unless a new result meets a full, stalled output register
  assign adv = !(ctl_q.vld && ctl_q.emit && out_valid && !out_ready);
  assign in_ready = (state == ata_pkg::ST_IDLE) && adv && !(ctl_q.vld && ctl_q.wr_row);
  assign accept = in_valid && in_ready;

  // issue: choose lane operands for this cycle
  always_comb begin
    ctl_s = '0;
    for (int l = 0; l < ata_pkg::LANES; l++) begin
      lbias[l] = '0;
      for (int k = 0; k < 4; k++) begin
        la[l][k] = '0;
        lb[l][k] = '0;
      end
    end
    if (state == ata_pkg::ST_COMPOSE) begin
      ctl_s.vld = 1'b1;
      ctl_s.wr_row = 1'b1;
      ctl_s.row = pass;
      for (int l = 0; l < ata_pkg::LANES; l++) begin
        for (int k = 0; k < 4; k++) begin
          if (world) begin
            la[l][k] = m[{pass, 2'b00} + 4'(k)];
            lb[l][k] = opx[4'(k*4 + l)];
          end else begin
            la[l][k] = opx[{pass, 2'b00} + 4'(k)];
            lb[l][k] = m[4'(k*4 + l)];
          end
        end
      end
    end else if (state == ata_pkg::ST_INVERSE) begin
      ctl_s.vld = 1'b1;
      ctl_s.emit = 1'b1;
      ctl_s.row = pass;
      ctl_s.negate = (pass == 2'd3);
      ctl_s.last = (pass == 2'd3);
      // lanes 0..2 form -(t . R row i); rows 0..2 are a plain transpose
      for (int l = 0; l < 3; l++) begin
        for (int k = 0; k < 3; k++) begin
          la[l][k] = m[4'(12 + k)];
          lb[l][k] = m[4'(l*4 + k)];
        end
      end
    end else if (accept && (mode == ata_pkg::MODE_POINT ||
                            mode == ata_pkg::MODE_READ_POS)) begin
      ctl_s.vld = 1'b1;
      ctl_s.emit = 1'b1;
      ctl_s.last = 1'b1;
      ctl_s.use_bias = 1'b1;
      for (int l = 0; l < 3; l++) begin
        lbias[l] = m[4'(12 + l)];
        if (mode == ata_pkg::MODE_POINT) begin
          for (int k = 0; k < 3; k++) begin
            la[l][k] = vin[k];
            lb[l][k] = m[4'(k*4 + l)];
          end
        end
      end
    end
  end

  for (genvar g = 0; g < ata_pkg::LANES; g++) begin : g_lane
    ata_lane #(.WORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_lane (
      .clk(clk), .en(adv), .a(la[g]), .b(lb[g]), .bias(lbias[g]),
      .negate(ctl_s.negate), .res(lres[g])
    );
  end

  // lane results form the new row; inverse rows 0..2 are transposed at the output
  always_comb begin
    for (int l = 0; l < 4; l++) newrow[l] = lres[l];
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ata_pkg::ST_IDLE: begin
        if (accept && mode == ata_pkg::MODE_INVERSE) begin
          state_next = ata_pkg::ST_INVERSE;
        end else if (accept && (mode == ata_pkg::MODE_TRANSLATE ||
                     (mode == ata_pkg::MODE_OPERAND && row_index == 2'd3))) begin
          state_next = ata_pkg::ST_COMPOSE;
        end
      end
      ata_pkg::ST_COMPOSE, ata_pkg::ST_INVERSE: begin
        if (adv && pass == 2'd3) state_next = ata_pkg::ST_IDLE;
      end
      default: state_next = ata_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ata_pkg::ST_IDLE;
      pass  <= '0;
      ctl_q <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state != ata_pkg::ST_IDLE && adv) pass <= pass + 2'd1;
      if (state == ata_pkg::ST_IDLE) pass <= '0;
      if (adv) ctl_q <= ctl_s;
      if (adv && ctl_q.vld && ctl_q.emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // operand capture and mode side state
  always_ff @(posedge clk) begin
    if (accept) begin
      world  <= frame;
      is_trn <= (mode == ata_pkg::MODE_TRANSLATE);
      if (mode == ata_pkg::MODE_TRANSLATE) begin
        for (int i = 0; i < 3; i++) op[12 + i] <= vin[i];
        op[15] <= ONE;
      end else if (mode == ata_pkg::MODE_OPERAND) begin
        for (int i = 0; i < 4; i++) op[{row_index, 2'b00} + 4'(i)] <= vin[i];
      end
    end
  end

  // transform storage; compose rows land in a buffer, copied after the last
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) m[i] <= (i % 5 == 0) ? ONE : '0;
    end else begin
      if (accept && mode == ata_pkg::MODE_SET_POS) begin
        for (int i = 0; i < 3; i++) m[12 + i] <= vin[i];
      end
      if (accept && mode == ata_pkg::MODE_CLEAR_ROT) begin
        for (int i = 0; i < 3; i++) begin
          for (int k = 0; k < 3; k++) m[i*4 + k] <= (i == k) ? ONE : '0;
        end
      end
      if (adv && ctl_q.vld && ctl_q.wr_row && ctl_q.row == 2'd3) begin
        for (int i = 0; i < 12; i++) m[i] <= cmp_buf[i];
        for (int i = 0; i < 4; i++) m[12 + i] <= newrow[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && ctl_q.vld && ctl_q.wr_row) begin
      for (int i = 0; i < 4; i++) cmp_buf[{ctl_q.row, 2'b00} + 4'(i)] <= newrow[i];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv && ctl_q.vld && ctl_q.emit) begin
      last <= ctl_q.last;
      if (ctl_q.use_bias) begin
        out_row <= '0;
        res0 <= emit_f(newrow[0]);
        res1 <= emit_f(newrow[1]);
        res2 <= emit_f(newrow[2]);
        res3 <= '0;
      end else if (ctl_q.row == 2'd3) begin
        out_row <= ctl_q.row;
        res0 <= emit_f(newrow[0]);
        res1 <= emit_f(newrow[1]);
        res2 <= emit_f(newrow[2]);
        res3 <= emit_f(ONE);
      end else begin
        out_row <= ctl_q.row;
        res0 <= emit_f(m[{2'b00, ctl_q.row}]);
        res1 <= emit_f(m[4'd4 + {2'b00, ctl_q.row}]);
        res2 <= emit_f(m[4'd8 + {2'b00, ctl_q.row}]);
        res3 <= '0;
      end
    end
  end
endmodule

>>> src/ata_checker.sv
// ----------------------------------------------------------------------------
// ata_checker
// port level checks of the transform block, bound to the top level
// ----------------------------------------------------------------------------
`include "affine_transform_accumulator_macros.svh"
module ata_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [2:0] mode,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_row,
  input logic signed [31:0] res3,
  input logic       last
);
  // a stalled result holds its row number
  `ATA_ASSERT_NEXT(a_row_hold, out_valid && !out_ready, $stable(out_row))
  // only the final inverse row carries a nonzero row number with last
  `ATA_ASSERT_IMP(a_last_row, out_valid && last && out_row != 2'd0, out_row == 2'd3)
  // inverse rows before the last have a zero fourth column
  `ATA_ASSERT_IMP(a_res3_zero, out_valid && !last, res3 == 32'sd0)
  // no result appears right after reset
  `ATA_ASSERT_IMP(a_rst_empty, $fell(rst), !out_valid)
  // an accepted inverse read blocks the input on the next cycle
  `ATA_ASSERT_NEXT(a_inv_busy, in_valid && in_ready && mode == ata_pkg::MODE_INVERSE, !in_ready)
endmodule

bind affine_transform_accumulator ata_checker u_ata_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .mode(mode),
  .out_valid(out_valid), .out_ready(out_ready), .out_row(out_row),
  .res3(res3), .last(last)
);
